// File: rtl/core/hsfc_pkg.sv
`timescale 1ns / 1ps

package hsfc_pkg;

  localparam logic [2:0] FRAME_LAST = 3'd5;
  localparam logic [2:0] CRC_POS_0  = 3'd2;
  localparam logic [2:0] CRC_POS_1  = 3'd5;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_SERIAL  = 1'b1;

  // One completed frame as handed from the front to the back.
  typedef struct packed {
    logic        kind;
    logic [1:0]  fail;
    logic [31:0] payload;
  } frame_t;

endpackage

// File: rtl/core/hsfc_byte_if.sv
`timescale 1ns / 1ps

interface hsfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_kind;
  logic       frame_start;

  modport source (output valid, data_byte, frame_kind, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_kind, frame_start, output ready);
endinterface

// File: rtl/core/hsfc_result_if.sv
`timescale 1ns / 1ps

interface hsfc_result_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [1:0]         crc_fail_count;
  logic signed [17:0] temperature_milli_c;
  logic [16:0]        humidity_milli_pct;
  logic [31:0]        serial_value;
  logic [15:0]        good_count;

  modport source (output valid, result_kind, crc_fail_count, temperature_milli_c,
                  humidity_milli_pct, serial_value, good_count, input ready);
  modport sink   (input valid, result_kind, crc_fail_count, temperature_milli_c,
                  humidity_milli_pct, serial_value, good_count, output ready);
endinterface

// File: rtl/core/humidity_sensor_frame_checker.sv
`timescale 1ns / 1ps
// Takes one byte per cycle; ready drops only while the two-entry frame queue is full.
// A completed frame passes the queue write, the multiply stage and the divide/clamp
// into the output register, in that order; back-pressure on results can hold it.
// Throughput: one byte per cycle except while the queue is full, one result per frame.
// Synchronous active-high reset clears frame position, queue and all stored readings.
module humidity_sensor_frame_checker (
  input  logic          clk,
  input  logic          rst,
  hsfc_byte_if.sink     frame_bytes,
  hsfc_result_if.source results
);

  logic             push;
  hsfc_pkg::frame_t push_frame;
  logic             full;
  logic             pop_valid;
  logic             pop_ready;
  hsfc_pkg::frame_t pop_frame;

  hsfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_bytes (frame_bytes),
    .push        (push),
    .push_frame  (push_frame),
    .full        (full)
  );

  hsfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  hsfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (pop_valid),
    .frame_ready (pop_ready),
    .frame       (pop_frame),
    .results     (results)
  );

endmodule

// File: rtl/core/hsfc_front.sv
`timescale 1ns / 1ps

module hsfc_front (
  input  logic            clk,
  input  logic            rst,
  hsfc_byte_if.sink       frame_bytes,
  output logic            push,
  output hsfc_pkg::frame_t push_frame,
  input  logic            full
);

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [2:0] FRAME_LEN = 3'd6;

  logic [2:0]  pos;
  logic [7:0]  crc;
  logic [31:0] payload;
  logic [1:0]  tally;
  logic        kind;

  logic [2:0]  pos_eff;
  logic        first;
  logic [7:0]  crc_base;
  logic [31:0] payload_base;
  logic [1:0]  tally_base;
  logic        kind_eff;
  logic        is_check;
  logic [7:0]  crc_next;
  logic [31:0] payload_next;
  logic [1:0]  tally_next;
  logic        accept;

  function automatic logic [7:0] crc8_step(input logic [7:0] c_in, input logic [7:0] b);
    logic [7:0] c;
    c = c_in ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  assign frame_bytes.ready = !full;
  assign accept = frame_bytes.valid && frame_bytes.ready;

  always_comb begin
    pos_eff = (frame_bytes.frame_start || pos >= FRAME_LEN) ? 3'd0 : pos;
    first = (pos_eff == 3'd0);
    crc_base = first ? CRC_INIT : crc;
    payload_base = first ? 32'd0 : payload;
    tally_base = first ? 2'd0 : tally;
    kind_eff = first ? frame_bytes.frame_kind : kind;
    is_check = (pos_eff == hsfc_pkg::CRC_POS_0) || (pos_eff == hsfc_pkg::CRC_POS_1);
    if (is_check) begin
      crc_next = CRC_INIT;
      payload_next = payload_base;
      tally_next = tally_base + 2'((frame_bytes.data_byte != crc_base) ? 1 : 0);
    end else begin
      crc_next = crc8_step(crc_base, frame_bytes.data_byte);
      payload_next = {payload_base[23:0], frame_bytes.data_byte};
      tally_next = tally_base;
    end
  end

  assign push = accept && (pos_eff == hsfc_pkg::FRAME_LAST);
  assign push_frame = '{kind: kind_eff, fail: tally_next, payload: payload_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
      crc <= CRC_INIT;
      payload <= 32'd0;
      tally <= 2'd0;
      kind <= 1'b0;
    end else if (accept) begin
      pos <= (pos_eff == hsfc_pkg::FRAME_LAST) ? 3'd0 : pos_eff + 3'd1;
      crc <= crc_next;
      payload <= payload_next;
      tally <= tally_next;
      kind <= kind_eff;
    end
  end

endmodule

// File: rtl/core/hsfc_queue.sv
`timescale 1ns / 1ps

module hsfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hsfc_pkg::frame_t push_frame,
  output logic             full,
  output logic             pop_valid,
  input  logic             pop_ready,
  output hsfc_pkg::frame_t pop_frame
);

  hsfc_pkg::frame_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop = pop_valid && pop_ready;
  assign pop_frame = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/hsfc_back.sv
`timescale 1ns / 1ps

module hsfc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_ready,
  input  hsfc_pkg::frame_t frame,
  hsfc_result_if.source    results
);

  localparam logic [17:0] TEMP_SPAN   = 18'd175000;
  localparam logic [17:0] TEMP_OFFSET = 18'd45000;
  localparam logic [17:0] HUM_SPAN    = 18'd125000;
  localparam logic [17:0] HUM_OFFSET  = 18'd6000;
  localparam logic [17:0] HUM_MAX     = 18'd100000;

  logic        s1_valid;
  logic        s1_kind;
  logic [1:0]  s1_fail;
  logic [31:0] s1_payload;
  logic [33:0] prod_t;
  logic [33:0] prod_h;
  logic        s1_adv;

  logic [17:0] q_t;
  logic [17:0] q_h;
  logic [17:0] h_diff;
  logic [16:0] hum_val;

  // Floor division by 2^16 - 1: fold the high part back twice, then one correction.
  function automatic logic [17:0] div65535(input logic [33:0] n);
    logic [17:0] q0;
    logic [18:0] r;
    logic [2:0]  q1;
    logic [16:0] r1;
    q0 = n[33:16];
    r = 19'(n[15:0]) + 19'(q0);
    q1 = r[18:16];
    r1 = 17'(r[15:0]) + 17'(q1);
    return q0 + 18'(q1) + 18'((r1 >= 17'd65535) ? 1 : 0);
  endfunction

  assign s1_adv = s1_valid && (!results.valid || results.ready);
  assign frame_ready = !s1_valid || s1_adv;

  always_comb begin
    q_t = div65535(prod_t);
    q_h = div65535(prod_h);
    h_diff = q_h - HUM_OFFSET;
    if (q_h < HUM_OFFSET) begin
      hum_val = 17'd0;
    end else if (h_diff > HUM_MAX) begin
      hum_val = HUM_MAX[16:0];
    end else begin
      hum_val = h_diff[16:0];
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_ready) begin
      s1_valid <= frame_valid;
    end
    if (frame_valid && frame_ready) begin
      s1_kind <= frame.kind;
      s1_fail <= frame.fail;
      s1_payload <= frame.payload;
      prod_t <= 34'(frame.payload[31:16]) * 34'(TEMP_SPAN);
      prod_h <= 34'(frame.payload[15:0]) * 34'(HUM_SPAN);
    end
  end

  // Output register doubles as the stored readings
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      results.result_kind <= 1'b0;
      results.crc_fail_count <= 2'd0;
      results.temperature_milli_c <= 18'sd0;
      results.humidity_milli_pct <= 17'd0;
      results.serial_value <= 32'd0;
      results.good_count <= 16'd0;
    end else if (s1_adv) begin
      results.valid <= 1'b1;
      results.result_kind <= s1_kind;
      results.crc_fail_count <= s1_fail;
      if (s1_fail == 2'd0) begin
        if (s1_kind == hsfc_pkg::KIND_SERIAL) begin
          results.serial_value <= s1_payload;
        end else begin
          results.temperature_milli_c <= signed'(q_t - TEMP_OFFSET);
          results.humidity_milli_pct <= hum_val;
          results.good_count <= results.good_count + 16'd1;
        end
      end
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [7:0] CRC_SEED    = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h31;
  localparam int         HUM_CEIL    = 100000;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         PRINT_CAP   = 40;

  typedef struct packed {
    logic               kind;
    logic [1:0]         fails;
    logic signed [17:0] temp;
    logic [16:0]        hum;
    logic [31:0]        serial;
    logic [15:0]        good;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hsfc_byte_if   byte_link ();
  hsfc_result_if result_link ();

  humidity_sensor_frame_checker dut (
    .clk        (clk),
    .rst        (rst),
    .frame_bytes(byte_link),
    .results    (result_link)
  );

  // Frame tracker state, mirrors the block's own registers.
  logic [2:0]         pos_q;
  logic [7:0]         crc_q;
  logic [31:0]        payload_q;
  logic [1:0]         fails_q;
  logic               kind_q;
  logic signed [17:0] temp_q;
  logic [16:0]        hum_q;
  logic [31:0]        serial_q;
  logic [15:0]        good_q;

  reading_t expected_readings[$];
  int       mismatches = 0;
  int       results_checked = 0;
  int       quiet_cycles = 0;
  bit       idle_on = 1'b0;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] c;
    c = crc ^ value;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Mix of rail values, values around both humidity clamp points, and random words.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(3140 + $urandom_range(0, 12));
      3: return 16'(55568 + $urandom_range(0, 12));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("tb_top: mismatch on %s at result %0d: got %0d, want %0d",
               what, results_checked, got, want);
  endtask

  // Advance the tracker by one accepted byte; queue a reading when a frame completes.
  task automatic track_byte(input logic [7:0] value, input logic kind, input logic start);
    logic [2:0] p;
    longint     w0, w1, t, h;
    reading_t   r;
    p = pos_q;
    if (start || p > hsfc_pkg::FRAME_LAST) p = 3'd0;
    if (p == 3'd0) begin
      kind_q    = kind;
      crc_q     = CRC_SEED;
      fails_q   = 2'd0;
      payload_q = 32'd0;
    end
    if (p == hsfc_pkg::CRC_POS_0 || p == hsfc_pkg::CRC_POS_1) begin
      if (value != crc_q) fails_q = fails_q + 2'd1;
      crc_q = CRC_SEED;
    end else begin
      crc_q     = crc8_step(crc_q, value);
      payload_q = {payload_q[23:0], value};
    end
    if (p != hsfc_pkg::FRAME_LAST) begin
      pos_q = p + 3'd1;
      return;
    end
    pos_q = 3'd0;
    if (fails_q == 2'd0) begin
      if (kind_q == hsfc_pkg::KIND_SERIAL) begin
        serial_q = payload_q;
      end else begin
        w0 = payload_q[31:16];
        w1 = payload_q[15:0];
        t  = (175000 * w0) / 65535 - 45000;
        h  = (125000 * w1) / 65535 - 6000;
        if (h < 0) h = 0;
        if (h > HUM_CEIL) h = HUM_CEIL;
        temp_q = t[17:0];
        hum_q  = h[16:0];
        good_q = good_q + 16'd1;
      end
    end
    r = '{kind: kind_q, fails: fails_q, temp: temp_q, hum: hum_q,
          serial: serial_q, good: good_q};
    expected_readings.push_back(r);
  endtask

  // Hold valid until the transaction goes through; idle bursts come before it.
  task automatic send_byte(input logic [7:0] value, input logic kind, input logic start);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_link.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_link.valid       <= 1'b1;
    byte_link.data_byte   <= value;
    byte_link.frame_kind  <= kind;
    byte_link.frame_start <= start;
    @(posedge clk);
    while (!byte_link.ready) @(posedge clk);
    track_byte(value, kind, start);
  endtask

  // Send the first nbytes of a frame; a bad flag flips bits of that word's CRC byte.
  task automatic send_frame(input logic kind, input logic [15:0] w0, input logic [15:0] w1,
                            input logic bad0, input logic bad1, input logic start,
                            input int nbytes);
    logic [7:0] seq [6];
    logic [7:0] c0, c1;
    c0 = crc8_step(crc8_step(CRC_SEED, w0[15:8]), w0[7:0]);
    c1 = crc8_step(crc8_step(CRC_SEED, w1[15:8]), w1[7:0]);
    if (bad0) c0 = c0 ^ 8'($urandom_range(1, 255));
    if (bad1) c1 = c1 ^ 8'($urandom_range(1, 255));
    seq = '{w0[15:8], w0[7:0], c0, w1[15:8], w1[7:0], c1};
    for (int i = 0; i < nbytes; i++) begin
      // Kind only counts at byte zero; scramble it on the rest.
      if (i == 0)
        send_byte(seq[i], kind, start || pos_q != 3'd0);
      else
        send_byte(seq[i], 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic test_conversion_extremes();
    send_frame(hsfc_pkg::KIND_MEASURE, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
    send_frame(hsfc_pkg::KIND_MEASURE, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
  endtask

  task automatic test_serial_frame();
    send_frame(hsfc_pkg::KIND_SERIAL, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
  endtask

  task automatic test_restart_and_crc_failures();
    // Drop a partial serial frame, then a measurement frame with both words bad.
    send_frame(hsfc_pkg::KIND_SERIAL, 16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 2);
    send_frame(hsfc_pkg::KIND_MEASURE, 16'h8000, 16'h4000, 1'b1, 1'b1, 1'b1, 6);
  endtask

  task automatic test_random_traffic(input int rounds, input bit bursts);
    int sel;
    int noise_len;
    for (int r = 0; r < rounds; r++) begin
      if (r % 20 == 0) idle_on = bursts && $urandom_range(0, 3) != 0;
      sel = $urandom_range(0, 19);
      if (sel < 17) begin
        send_frame(1'($urandom_range(0, 1)), pick_word(), pick_word(),
                   $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                   1'($urandom_range(0, 1)), 6);
      end else if (sel < 19) begin
        send_frame(1'($urandom_range(0, 1)), pick_word(), pick_word(),
                   1'b0, 1'b0, 1'($urandom_range(0, 1)), $urandom_range(1, 5));
      end else begin
        noise_len = $urandom_range(1, 3);
        repeat (noise_len)
          send_byte(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin : result_sink
    reading_t want;
    int       stall_left;
    stall_left = 0;
    result_link.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_link.valid && result_link.ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_readings.pop_front();
          if (result_link.result_kind !== want.kind)
            report_mismatch("result_kind", result_link.result_kind, want.kind);
          if (result_link.crc_fail_count !== want.fails)
            report_mismatch("crc_fail_count", result_link.crc_fail_count, want.fails);
          if (result_link.temperature_milli_c !== want.temp)
            report_mismatch("temperature_milli_c", $signed(result_link.temperature_milli_c),
                            $signed(want.temp));
          if (result_link.humidity_milli_pct !== want.hum)
            report_mismatch("humidity_milli_pct", result_link.humidity_milli_pct, want.hum);
          if (result_link.serial_value !== want.serial)
            report_mismatch("serial_value", result_link.serial_value, want.serial);
          if (result_link.good_count !== want.good)
            report_mismatch("good_count", result_link.good_count, want.good);
        end
        results_checked++;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 4);
      if (rst) begin
        result_link.ready <= 1'b0;
      end else if (stall_left != 0) begin
        result_link.ready <= 1'b0;
        stall_left--;
      end else begin
        result_link.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_link.valid && byte_link.ready) || (result_link.valid && result_link.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    byte_link.valid       = 1'b0;
    byte_link.data_byte   = 8'd0;
    byte_link.frame_kind  = 1'b0;
    byte_link.frame_start = 1'b0;
    pos_q     = 3'd0;
    crc_q     = CRC_SEED;
    payload_q = 32'd0;
    fails_q   = 2'd0;
    kind_q    = hsfc_pkg::KIND_MEASURE;
    temp_q    = 18'sd0;
    hum_q     = 17'd0;
    serial_q  = 32'd0;
    good_q    = 16'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    test_conversion_extremes();
    test_serial_frame();
    test_restart_and_crc_failures();
    test_random_traffic(240, 1'b1);
    test_random_traffic(80, 1'b0);
    byte_link.valid <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
